FILE: src/assert_macros.svh
// Assertion macros shared by the free extent table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CFET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CFET_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("reset assertion failed");
`else
`define CFET_ASSERT(lbl, prop)
`define CFET_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: src/cfet_pkg.sv
// Constants, types and helpers for the coalescing free extent table.
package cfet_pkg;

  localparam int ENTRIES    = 64;
  localparam int SPACE_BITS = 20;
  localparam int LEN_W      = SPACE_BITS + 1;
  localparam int SUM_W      = LEN_W + 1;
  localparam int SUM3_W     = LEN_W + 2;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(1) << SPACE_BITS;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [2:0] ST_INSERTED      = 3'd0;
  localparam logic [2:0] ST_MERGED_BEFORE = 3'd1;
  localparam logic [2:0] ST_MERGED_AFTER  = 3'd2;
  localparam logic [2:0] ST_MERGED_BOTH   = 3'd3;
  localparam logic [2:0] ST_FULL          = 3'd4;
  localparam logic [2:0] ST_READ_OK       = 3'd5;
  localparam logic [2:0] ST_EMPTY         = 3'd6;
  localparam logic [2:0] ST_CLEARED       = 3'd7;

  typedef struct packed {
    logic [SPACE_BITS-1:0] start;
    logic [LEN_W-1:0]      len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [LEN_W-1:0] sat_len(input logic [SUM3_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v > SUM3_W'(LEN_MAX)) r = LEN_MAX;
    else r = v[LEN_W-1:0];
    return r;
  endfunction

endpackage

FILE: src/cfet_ram.sv
// Generic simple dual port RAM with registered read.
module cfet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: src/coalescing_free_extent_table_core.sv
// Top level: sorted free extent table with merge on add, held in one RAM.
// Clear and bad reads go straight to the response; a read fetches the entry
// first; an add scans, decides and merges, and shifts entries when it inserts
// or merges both sides; the scan and shift walk the RAM one entry per cycle.
// One item at a time: in_stall is high until the block is back in idle.
// Reset (synchronous, rst_n low) empties the table; RAM contents are kept.
module coalescing_free_extent_table_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic [cfet_pkg::SPACE_BITS-1:0]   in_start_addr,
  input  logic [cfet_pkg::LEN_W-1:0]        in_extent_len,
  input  logic [cfet_pkg::IDX_W-1:0]        in_entry_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [cfet_pkg::SPACE_BITS-1:0]   out_entry_start,
  output logic [cfet_pkg::LEN_W-1:0]        out_entry_len,
  output logic [cfet_pkg::CNT_W-1:0]        out_entry_total
);
  import cfet_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_MERGE, S_SHIFT, S_READ, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      chk_r, chk_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      sp_r, sp_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [IDX_W-1:0]      dst_r, dst_nxt;
  logic                  pend_r, pend_nxt;
  logic                  dir_up_r, dir_up_nxt;
  logic                  has_prev_r, has_prev_nxt;
  logic                  has_next_r, has_next_nxt;
  logic                  jp_r, jp_nxt;
  logic                  jn_r, jn_nxt;
  logic [SPACE_BITS-1:0] loc_r, loc_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  entry_t                prev_r, prev_nxt;
  entry_t                next_r, next_nxt;
  logic [SUM_W-1:0]      sum_pl_r, sum_pl_nxt;
  logic [SUM_W-1:0]      sum_nl_r, sum_nl_nxt;
  logic [2:0]            res_st_r, res_st_nxt;
  logic [SPACE_BITS-1:0] res_start_r, res_start_nxt;
  logic [LEN_W-1:0]      res_len_r, res_len_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [2:0]            out_st_r, out_st_nxt;
  logic [SPACE_BITS-1:0] out_start_r, out_start_nxt;
  logic [LEN_W-1:0]      out_len_r, out_len_nxt;
  logic [CNT_W-1:0]      out_total_r, out_total_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  entry_t                ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  entry_t                ram_rdata;
  logic [ENTRY_W-1:0]    ram_rbits;

  logic [CNT_W-1:0]      pos_m1;
  logic [CNT_W-1:0]      sp_step;
  logic [CNT_W-1:0]      dst_step;
  logic [SUM3_W-1:0]     tot3;

  cfet_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_entry_start = out_start_r;
  assign out_entry_len   = out_len_r;
  assign out_entry_total = out_total_r;

  assign pos_m1   = pos_r - CNT_W'(1);
  assign sp_step  = dir_up_r ? (sp_r - CNT_W'(1)) : (sp_r + CNT_W'(1));
  assign dst_step = dir_up_r ? (sp_r + CNT_W'(1)) : (sp_r - CNT_W'(1));
  assign tot3     = SUM3_W'(sum_pl_r) + SUM3_W'(next_r.len);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    chk_nxt       = chk_r;
    pos_nxt       = pos_r;
    sp_nxt        = sp_r;
    rem_nxt       = rem_r;
    dst_nxt       = dst_r;
    pend_nxt      = pend_r;
    dir_up_nxt    = dir_up_r;
    has_prev_nxt  = has_prev_r;
    has_next_nxt  = has_next_r;
    jp_nxt        = jp_r;
    jn_nxt        = jn_r;
    loc_nxt       = loc_r;
    len_nxt       = len_r;
    prev_nxt      = prev_r;
    next_nxt      = next_r;
    sum_pl_nxt    = sum_pl_r;
    sum_nl_nxt    = sum_nl_r;
    res_st_nxt    = res_st_r;
    res_start_nxt = res_start_r;
    res_len_nxt   = res_len_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_start_nxt = out_start_r;
    out_len_nxt   = out_len_r;
    out_total_nxt = out_total_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        ram_raddr = in_entry_index;
        if (in_valid) begin
          res_start_nxt = '0;
          res_len_nxt   = '0;
          case (in_kind)
            KIND_CLEAR: begin
              cnt_nxt    = '0;
              res_st_nxt = ST_CLEARED;
              state_nxt  = S_RESP;
            end
            KIND_ADD: begin
              loc_nxt      = in_start_addr;
              len_nxt      = sat_len(SUM3_W'(in_extent_len));
              ptr_nxt      = '0;
              pend_nxt     = 1'b0;
              has_prev_nxt = 1'b0;
              has_next_nxt = 1'b0;
              pos_nxt      = '0;
              state_nxt    = (cnt_r == '0) ? S_DECIDE : S_SCAN;
            end
            KIND_READ: begin
              if (CNT_W'(in_entry_index) < cnt_r) begin
                state_nxt = S_READ;
              end else begin
                res_st_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end
            end
            default: begin
              res_st_nxt = ST_EMPTY;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // reads run one entry ahead of the compare
        ram_raddr = ptr_r[IDX_W-1:0];
        ptr_nxt   = ptr_r + CNT_W'(1);
        chk_nxt   = ptr_r;
        pend_nxt  = 1'b1;
        if (pend_r) begin
          if (ram_rdata.start >= loc_r) begin
            pos_nxt      = chk_r;
            next_nxt     = ram_rdata;
            has_next_nxt = 1'b1;
            state_nxt    = S_DECIDE;
          end else begin
            prev_nxt     = ram_rdata;
            has_prev_nxt = 1'b1;
            if ((chk_r + CNT_W'(1)) == cnt_r) begin
              pos_nxt   = cnt_r;
              state_nxt = S_DECIDE;
            end
          end
        end
      end
      S_DECIDE: begin
        jp_nxt = has_prev_r &&
                 ((SUM_W'(prev_r.start) + SUM_W'(prev_r.len)) == SUM_W'(loc_r));
        jn_nxt = has_next_r &&
                 ((SUM_W'(loc_r) + SUM_W'(len_r)) == SUM_W'(next_r.start));
        sum_pl_nxt = SUM_W'(prev_r.len) + SUM_W'(len_r);
        sum_nl_nxt = SUM_W'(next_r.len) + SUM_W'(len_r);
        state_nxt  = S_MERGE;
      end
      S_MERGE: begin
        pend_nxt = 1'b0;
        if (jp_r && jn_r) begin
          ram_we          = 1'b1;
          ram_waddr       = pos_m1[IDX_W-1:0];
          ram_wdata.start = prev_r.start;
          ram_wdata.len   = sat_len(tot3);
          sp_nxt          = pos_r + CNT_W'(1);
          rem_nxt         = cnt_r - pos_r - CNT_W'(1);
          dir_up_nxt      = 1'b0;
          cnt_nxt         = cnt_r - CNT_W'(1);
          res_st_nxt      = ST_MERGED_BOTH;
          state_nxt       = S_SHIFT;
        end else if (jp_r) begin
          ram_we          = 1'b1;
          ram_waddr       = pos_m1[IDX_W-1:0];
          ram_wdata.start = prev_r.start;
          ram_wdata.len   = sat_len(SUM3_W'(sum_pl_r));
          res_st_nxt      = ST_MERGED_BEFORE;
          state_nxt       = S_RESP;
        end else if (jn_r) begin
          ram_we          = 1'b1;
          ram_waddr       = pos_r[IDX_W-1:0];
          ram_wdata.start = loc_r;
          ram_wdata.len   = sat_len(SUM3_W'(sum_nl_r));
          res_st_nxt      = ST_MERGED_AFTER;
          state_nxt       = S_RESP;
        end else if (cnt_r >= CNT_W'(ENTRIES)) begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          sp_nxt     = cnt_r - CNT_W'(1);
          rem_nxt    = cnt_r - pos_r;
          dir_up_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
          res_st_nxt = ST_INSERTED;
          state_nxt  = S_SHIFT;
        end
      end
      S_SHIFT: begin
        ram_raddr = sp_r[IDX_W-1:0];
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = ram_rdata;
        end
        if (rem_r != '0) begin
          sp_nxt   = sp_step;
          dst_nxt  = dst_step[IDX_W-1:0];
          rem_nxt  = rem_r - CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            // on an insert the gap is open: drop the new extent in
            if (dir_up_r) begin
              ram_we          = 1'b1;
              ram_waddr       = pos_r[IDX_W-1:0];
              ram_wdata.start = loc_r;
              ram_wdata.len   = len_r;
            end
            state_nxt = S_RESP;
          end
        end
      end
      S_READ: begin
        res_start_nxt = ram_rdata.start;
        res_len_nxt   = ram_rdata.len;
        res_st_nxt    = ST_READ_OK;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_start_nxt = res_start_r;
          out_len_nxt   = res_len_r;
          out_total_nxt = cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    chk_r       <= chk_nxt;
    pos_r       <= pos_nxt;
    sp_r        <= sp_nxt;
    rem_r       <= rem_nxt;
    dst_r       <= dst_nxt;
    dir_up_r    <= dir_up_nxt;
    has_prev_r  <= has_prev_nxt;
    has_next_r  <= has_next_nxt;
    jp_r        <= jp_nxt;
    jn_r        <= jn_nxt;
    loc_r       <= loc_nxt;
    len_r       <= len_nxt;
    prev_r      <= prev_nxt;
    next_r      <= next_nxt;
    sum_pl_r    <= sum_pl_nxt;
    sum_nl_r    <= sum_nl_nxt;
    res_st_r    <= res_st_nxt;
    res_start_r <= res_start_nxt;
    res_len_r   <= res_len_nxt;
    out_st_r    <= out_st_nxt;
    out_start_r <= out_start_nxt;
    out_len_r   <= out_len_nxt;
    out_total_r <= out_total_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CFET_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(ENTRIES))
  `CFET_ASSERT(a_scan_in_range, (state_r == S_SCAN) && pend_r |-> chk_r < cnt_r)
  `CFET_ASSERT(a_write_in_table, ram_we |-> CNT_W'(ram_waddr) < (cnt_r > cnt_nxt ? cnt_r : cnt_nxt))
  `CFET_ASSERT(a_merge_has_nbr, (state_r == S_MERGE) && jn_r |-> pos_r < cnt_r)
  `CFET_ASSERT_RST(a_reset_empty, !rst_n |=> (state_r == S_IDLE) && (cnt_r == '0) && !out_valid_r)

endmodule
